>>> rtl/core/vpts_pkg.sv
// ----------------------------------------------------------------------------
// Valve pulse train sequencer package
// Beat types, action and register codes, phase encoding and small helpers
// shared by the sequencer RTL.
// ----------------------------------------------------------------------------
package vpts_pkg;

  // Number of valve channels that are wired up. Lines and sensors stay four wide.
  localparam int VALVE_COUNT = 4;
  localparam int TICKS_PER_MS_DEFAULT = 1000;

  localparam logic [3:0] CHANNEL_MASK =
    (VALVE_COUNT >= 4) ? 4'hF : 4'((1 << VALVE_COUNT) - 1);

  // Action codes of an input beat.
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_OPEN  = 3'd2;
  localparam logic [2:0] ACT_CLOSE = 3'd3;
  localparam logic [2:0] ACT_SCAN  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_PULSE_US  = 2'd1;
  localparam logic [1:0] CFG_GAP_US    = 2'd2;

  localparam logic [9:0]  THRESHOLD_RESET = 10'd512;
  localparam logic [15:0] PULSE_US_RESET  = 16'd750;
  localparam logic [15:0] GAP_US_RESET    = 16'd3000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRAIN_OPEN,
    PH_TRAIN_CLOSE,
    PH_SCAN_PULSE,
    PH_SCAN_GAP
  } phase_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  valve;
    logic [15:0] open_time;
    logic [15:0] close_time;
    logic [15:0] cycle_count;
    logic        open_in_micros;
    logic [9:0]  sensor_0;
    logic [9:0]  sensor_1;
    logic [9:0]  sensor_2;
    logic [9:0]  sensor_3;
  } vpts_in_t;

  typedef struct packed {
    logic [3:0] valve_lines;
    logic       busy_res;
    logic       sequence_done;
    logic       rejected;
  } vpts_out_t;

  function automatic logic [1:0] lowest_channel(input logic [3:0] bits);
    logic [1:0] idx;
    idx = '0;
    for (int i = 3; i >= 0; i--) begin
      if (bits[i]) idx = 2'(i);
    end
    return idx;
  endfunction

  function automatic logic [1:0] highest_channel(input logic [3:0] bits);
    logic [1:0] idx;
    idx = '0;
    for (int i = 0; i < 4; i++) begin
      if (bits[i]) idx = 2'(i);
    end
    return idx;
  endfunction

endpackage

>>> rtl/core/valve_pulse_train_sequencer_core.sv
// ----------------------------------------------------------------------------
// Valve pulse train sequencer core
// Four valve lines driven by open/close trains, direct commands and
// sensor-triggered scan pulses, timed by one-microsecond tick beats.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / in_data) carries one beat per
//   tick or command. Every accepted beat yields exactly one result beat on
//   the output channel (out_valid / out_stall / out_data) holding the line
//   levels and status after that beat took effect.
//   Unless the receiver stalls, the result of a beat accepted at edge n is
//   shown from edge n. Throughput is one beat per cycle while in_stall is
//   low; each beat is handled by a single pass of logic between the state
//   registers and the result register, with the time-length products of a
//   start command formed on its own beat.
//   When the receiver stalls, the result register holds its beat and one
//   more beat lands in a skid register; in_stall rises only while the skid
//   register is full, and it is also high during reset.
//   Reset closes all valves, makes the sequencer idle and loads the default
//   threshold, pulse and gap registers. Configuration writes are taken in
//   any cycle through cfg_wen / cfg_index / cfg_wdata and should only be
//   issued while no sequence is running.
// ----------------------------------------------------------------------------
module valve_pulse_train_sequencer_core
  import vpts_pkg::*;
#(
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  vpts_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output vpts_out_t out_data,
  input  logic      cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam longint MAX_LEN = 64'd65535 * longint'(TICKS_PER_MS);
  localparam int TW = $clog2(MAX_LEN + 1);

  // Configuration registers.
  logic [9:0]  trig_threshold;
  logic [15:0] trig_pulse_us;
  logic [15:0] trig_gap_us;

  // Sequencer state.
  phase_t        phase, phase_next;
  logic [3:0]    line_levels, line_levels_next;
  logic [TW-1:0] time_left, time_left_next;
  logic [15:0]   cycles_left, cycles_left_next;
  logic [1:0]    active_channel, active_channel_next;
  logic [3:0]    scan_pending, scan_pending_next;
  logic [TW-1:0] held_open_len, held_open_len_next;
  logic [TW-1:0] held_close_len, held_close_len_next;

  // Output register and skid stage.
  vpts_out_t result;
  vpts_out_t skid_data;
  logic      skid_valid;

  logic acc;
  logic busy;
  logic is_cmd;
  logic valve_ok;
  logic done;
  logic rej;
  logic pop;

  logic [TW-1:0] in_open_len;
  logic [TW-1:0] in_close_len;
  logic [TW-1:0] time_dec;
  logic [15:0]   cycles_dec;
  logic [3:0]    active_bit;
  logic [3:0]    valve_bit;
  logic [3:0]    sensor_hits;

  logic          scan_go;
  logic [3:0]    scan_p;
  logic [3:0]    scan_l;
  logic [1:0]    scan_ch;
  logic [3:0]    scan_bit;

  assign in_stall = skid_valid || rst;
  assign acc      = in_valid && !in_stall;
  assign busy     = (phase != PH_IDLE);
  assign is_cmd   = (in_data.action == ACT_START) || (in_data.action == ACT_OPEN) ||
                    (in_data.action == ACT_CLOSE) || (in_data.action == ACT_SCAN);
  assign valve_ok = int'(in_data.valve) < VALVE_COUNT;
  assign pop      = out_valid && !out_stall;

  assign in_close_len = TW'(in_data.close_time) * TW'(TICKS_PER_MS);
  assign in_open_len  = in_data.open_in_micros ? TW'(in_data.open_time)
                                               : TW'(in_data.open_time) * TW'(TICKS_PER_MS);

  assign time_dec   = (time_left != '0) ? time_left - TW'(1) : '0;
  assign cycles_dec = (cycles_left != '0) ? cycles_left - 16'd1 : '0;
  assign active_bit = 4'b0001 << active_channel;
  assign valve_bit  = 4'b0001 << in_data.valve;

  assign sensor_hits = {in_data.sensor_3 > trig_threshold, in_data.sensor_2 > trig_threshold,
                        in_data.sensor_1 > trig_threshold, in_data.sensor_0 > trig_threshold};

  assign scan_ch  = lowest_channel(scan_p);
  assign scan_bit = 4'b0001 << scan_ch;

  always_comb begin
    phase_next          = phase;
    line_levels_next    = line_levels;
    time_left_next      = time_left;
    cycles_left_next    = cycles_left;
    active_channel_next = active_channel;
    scan_pending_next   = scan_pending;
    held_open_len_next  = held_open_len;
    held_close_len_next = held_close_len;
    done    = 1'b0;
    rej     = 1'b0;
    scan_go = 1'b0;
    scan_p  = scan_pending;
    scan_l  = line_levels;

    if (acc) begin
      if (is_cmd && busy) begin
        rej = 1'b1;
      end else begin
        case (in_data.action)
          ACT_TICK: begin
            if (busy) begin
              time_left_next = time_dec;
              if (time_dec == '0) begin
                unique case (phase)
                  PH_TRAIN_OPEN: begin
                    line_levels_next = line_levels & ~active_bit;
                    if (held_close_len != '0) begin
                      phase_next     = PH_TRAIN_CLOSE;
                      time_left_next = held_close_len;
                    end else begin
                      // No close phase: the cycle ends right after the open phase.
                      cycles_left_next = cycles_dec;
                      if (cycles_dec == '0) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                      end else begin
                        line_levels_next = line_levels | active_bit;
                        phase_next       = PH_TRAIN_OPEN;
                        time_left_next   = held_open_len;
                      end
                    end
                  end
                  PH_TRAIN_CLOSE: begin
                    cycles_left_next = cycles_dec;
                    if (cycles_dec == '0) begin
                      phase_next = PH_IDLE;
                      done       = 1'b1;
                    end else if (held_open_len != '0) begin
                      line_levels_next = line_levels | active_bit;
                      phase_next       = PH_TRAIN_OPEN;
                      time_left_next   = held_open_len;
                    end else begin
                      time_left_next = held_close_len;
                    end
                  end
                  PH_SCAN_PULSE: begin
                    if (trig_gap_us != '0) begin
                      line_levels_next = line_levels & ~active_bit;
                      phase_next       = PH_SCAN_GAP;
                      time_left_next   = TW'(trig_gap_us);
                    end else begin
                      scan_go = 1'b1;
                      scan_l  = line_levels & ~active_bit;
                    end
                  end
                  PH_SCAN_GAP: begin
                    scan_go = 1'b1;
                  end
                  PH_IDLE: begin
                  end
                endcase
              end
            end
          end
          ACT_START: begin
            if (valve_ok) begin
              active_channel_next = in_data.valve;
              held_open_len_next  = in_open_len;
              held_close_len_next = in_close_len;
              cycles_left_next    = in_data.cycle_count;
              if (in_data.cycle_count == '0) begin
                done = 1'b1;
              end else if (in_open_len == '0 && in_close_len == '0) begin
                line_levels_next = line_levels & ~valve_bit;
                cycles_left_next = '0;
                done             = 1'b1;
              end else if (in_open_len != '0) begin
                line_levels_next = line_levels | valve_bit;
                phase_next       = PH_TRAIN_OPEN;
                time_left_next   = in_open_len;
              end else begin
                line_levels_next = line_levels & ~valve_bit;
                phase_next       = PH_TRAIN_CLOSE;
                time_left_next   = in_close_len;
              end
            end
          end
          ACT_OPEN: begin
            if (valve_ok) line_levels_next = line_levels | valve_bit;
          end
          ACT_CLOSE: begin
            if (valve_ok) line_levels_next = line_levels & ~valve_bit;
          end
          ACT_SCAN: begin
            scan_go = 1'b1;
            scan_p  = sensor_hits & CHANNEL_MASK;
          end
          default: begin
          end
        endcase
      end
    end

    // Start the next scan pulse, skipping zero-length pulses and gaps, or end the scan when no channel is pending.
    if (scan_go) begin
      if (scan_p == '0) begin
        line_levels_next  = scan_l;
        scan_pending_next = '0;
        phase_next        = PH_IDLE;
        time_left_next    = '0;
        done              = 1'b1;
      end else if (trig_pulse_us != '0) begin
        active_channel_next = scan_ch;
        scan_pending_next   = scan_p & ~scan_bit;
        line_levels_next    = scan_l | scan_bit;
        phase_next          = PH_SCAN_PULSE;
        time_left_next      = TW'(trig_pulse_us);
      end else if (trig_gap_us != '0) begin
        active_channel_next = scan_ch;
        scan_pending_next   = scan_p & ~scan_bit;
        line_levels_next    = scan_l & ~scan_bit;
        phase_next          = PH_SCAN_GAP;
        time_left_next      = TW'(trig_gap_us);
      end else begin
        // Every pending channel opens and closes within this same beat.
        active_channel_next = highest_channel(scan_p);
        scan_pending_next   = '0;
        line_levels_next    = scan_l & ~scan_p;
        phase_next          = PH_IDLE;
        time_left_next      = '0;
        done                = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_levels    <= '0;
      time_left      <= '0;
      cycles_left    <= '0;
      active_channel <= '0;
      scan_pending   <= '0;
      held_open_len  <= '0;
      held_close_len <= '0;
    end else begin
      line_levels    <= line_levels_next;
      time_left      <= time_left_next;
      cycles_left    <= cycles_left_next;
      active_channel <= active_channel_next;
      scan_pending   <= scan_pending_next;
      held_open_len  <= held_open_len_next;
      held_close_len <= held_close_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_threshold <= THRESHOLD_RESET;
      trig_pulse_us  <= PULSE_US_RESET;
      trig_gap_us    <= GAP_US_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_THRESHOLD: trig_threshold <= cfg_wdata[9:0];
        CFG_PULSE_US:  trig_pulse_us  <= cfg_wdata;
        CFG_GAP_US:    trig_gap_us    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Result beat for the accepted item; it goes to the skid stage when the
  // result register is still held by a stalled receiver.
  vpts_out_t new_result;
  assign new_result.valve_lines   = line_levels_next;
  assign new_result.busy_res      = (phase_next != PH_IDLE);
  assign new_result.sequence_done = done;
  assign new_result.rejected      = rej;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= acc;
      end
    end else if (acc) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      result <= skid_data;
    end else if (acc && (pop || !out_valid)) begin
      result <= new_result;
    end
    if (acc && out_valid && !pop) begin
      skid_data <= new_result;
    end
  end

  assign out_data = result;

  // A running phase always has time left to count down.
  a_time_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (time_left != '0))
    else $error("sequencer busy with no time left");

  // A train in progress always has at least one cycle to finish.
  a_train_cycles: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRAIN_OPEN || phase == PH_TRAIN_CLOSE) |-> (cycles_left != '0))
    else $error("train running with zero cycles left");

  // The active valve is driven during an open or pulse phase and released during a close or gap phase.
  a_open_line_high: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRAIN_OPEN || phase == PH_SCAN_PULSE) |-> line_levels[active_channel])
    else $error("active valve not driven during open phase");

  a_close_line_low: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRAIN_CLOSE || phase == PH_SCAN_GAP) |-> !line_levels[active_channel])
    else $error("active valve driven during closed phase");

  // A command refused while busy leaves the valves and phase untouched.
  a_reject_no_effect: assert property (@(posedge clk) disable iff (rst)
    (acc && busy && is_cmd) |=> ($stable(line_levels) && $stable(phase)))
    else $error("rejected command changed sequencer state");

  // The skid stage only fills behind a held result beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid beat without a result beat ahead of it");

endmodule
